// ----- rtl/core/mlcc_pkg.sv -----
// Shared types, codes and the coherence transition function of the MESI line controller.
package mlcc_pkg;

    localparam int NUM_LINES = 1024;
    localparam int NUM_NODES = 16;
    localparam int LINE_W    = $clog2(NUM_LINES);
    localparam int NODE_W    = $clog2(NUM_NODES);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // input mode codes
    localparam logic [2:0] MD_LOAD  = 3'd0;
    localparam logic [2:0] MD_STORE = 3'd1;
    localparam logic [2:0] MD_GETS  = 3'd2;
    localparam logic [2:0] MD_GETM  = 3'd3;
    localparam logic [2:0] MD_DATA  = 3'd4;

    // bus request codes
    localparam logic [1:0] BUS_NONE = 2'd0;
    localparam logic [1:0] BUS_GETS = 2'd1;
    localparam logic [1:0] BUS_GETM = 2'd2;
    localparam logic [1:0] BUS_DATA = 2'd3;

    // line state codes
    localparam logic [2:0] LS_I  = 3'd0;
    localparam logic [2:0] LS_S  = 3'd1;
    localparam logic [2:0] LS_E  = 3'd2;
    localparam logic [2:0] LS_M  = 3'd3;
    localparam logic [2:0] LS_IM = 3'd4;
    localparam logic [2:0] LS_IS = 3'd5;
    localparam logic [2:0] LS_SM = 3'd6;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_STORE,
        OP_GETS,
        OP_GETM,
        OP_DATA,
        OP_BAD
    } op_kind_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOK
    } bk_state_t;

    typedef struct packed {
        op_kind_t           op;
        logic [LINE_W-1:0]  idx;
        logic [NODE_W-1:0]  src;
        logic               shared;
    } item_t;

    typedef struct packed {
        logic [1:0] bus;
        logic       ready;
        logic       ashared;
        logic       miss;
        logic       upg;
        logic       illegal;
        logic [2:0] nst;
    } coh_res_t;

    typedef struct packed {
        logic [1:0]         bus;
        logic [LINE_W-1:0]  line;
        logic [NODE_W-1:0]  dest;
        logic               ready;
        logic               ashared;
        logic               miss;
        logic               upg;
        logic               illegal;
        logic [2:0]         nst;
    } out_t;

    function automatic coh_res_t coh_step(input logic [2:0] st, input op_kind_t op,
                                          input logic shared);
        coh_res_t r;
        r.bus     = BUS_NONE;
        r.ready   = 1'b0;
        r.ashared = 1'b0;
        r.miss    = 1'b0;
        r.upg     = 1'b0;
        r.illegal = 1'b0;
        r.nst     = st;
        if (op == OP_BAD || st > LS_SM) begin
            r.illegal = 1'b1;
        end else if (op == OP_LOAD || op == OP_STORE) begin
            case (st)
                LS_I: begin
                    r.bus  = (op == OP_STORE) ? BUS_GETM : BUS_GETS;
                    r.nst  = (op == OP_STORE) ? LS_IM : LS_IS;
                    r.miss = 1'b1;
                end
                LS_S: begin
                    if (op == OP_STORE) begin
                        r.bus = BUS_GETM;
                        r.nst = LS_SM;
                    end else begin
                        r.ready = 1'b1;
                    end
                end
                LS_E: begin
                    r.ready = 1'b1;
                    if (op == OP_STORE) begin
                        r.nst = LS_M;
                        r.upg = 1'b1;
                    end
                end
                LS_M: r.ready = 1'b1;
                default: r.illegal = 1'b1;
            endcase
        end else begin
            case (st)
                LS_S: begin
                    if (op == OP_GETS) r.ashared = 1'b1;
                    else if (op == OP_GETM) r.nst = LS_I;
                end
                LS_E, LS_M: begin
                    if (op == OP_GETS) begin
                        r.ashared = 1'b1;
                        r.bus     = BUS_DATA;
                        r.nst     = LS_S;
                    end else if (op == OP_GETM) begin
                        r.bus = BUS_DATA;
                        r.nst = LS_I;
                    end
                end
                LS_IM: begin
                    if (op == OP_DATA) begin
                        r.ready = 1'b1;
                        r.nst   = LS_M;
                    end
                end
                LS_IS: begin
                    if (op == OP_DATA) begin
                        r.ready = 1'b1;
                        r.nst   = shared ? LS_S : LS_E;
                    end
                end
                LS_SM: begin
                    if (op == OP_GETS) begin
                        r.ashared = 1'b1;
                    end else if (op == OP_GETM) begin
                        r.nst  = LS_IM;
                        r.miss = 1'b1;
                    end else begin
                        r.ready = 1'b1;
                        r.nst   = LS_M;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/mesi_line_coherence_controller.sv -----
// Top level of the MESI snooping line coherence controller.
//
// s_ channel: one beat per processor load/store or snooped GETS/GETM/DATA for one line.
// m_ channel: exactly one result beat per input beat, in order: bus request, line,
// DATA destination, processor data ready, shared assert, miss/upgrade/illegal flags
// and the new line state.
// Each beat is queued, its line state is read into a register, and the result is
// registered as the new state is written back to the line state memory (1024 x 3 bits);
// the sequencer takes a new beat only after the last one has been written back.
// A two-entry queue sits between the decoder and the state sequencer, so input beats
// keep being taken while a result waits; once it is full s_ready drops.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits with the next line state unchanged.
// Reset: after aresetn the memory is cleared to Invalid one line per cycle; s_ready
// stays low until every line has been cleared.
module mesi_line_coherence_controller (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_mode,
    input  logic [mlcc_pkg::LINE_W-1:0] s_line_index,
    input  logic [mlcc_pkg::NODE_W-1:0] s_source_node,
    input  logic                        s_shared_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_bus_request,
    output logic [mlcc_pkg::LINE_W-1:0] m_bus_line,
    output logic [mlcc_pkg::NODE_W-1:0] m_data_dest,
    output logic                        m_proc_data_ready,
    output logic                        m_assert_shared,
    output logic                        m_miss_flag,
    output logic                        m_upgrade_flag,
    output logic                        m_illegal_flag,
    output logic [2:0]                  m_line_state_out
);

    logic            init_done;
    logic            q_valid, q_ready;
    mlcc_pkg::item_t q_item;
    mlcc_pkg::out_t  m_out;

    mlcc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept_en     (init_done),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_line_index  (s_line_index),
        .s_source_node (s_source_node),
        .s_shared_in   (s_shared_in),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    mlcc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out     (m_out)
    );

    assign m_bus_request     = m_out.bus;
    assign m_bus_line        = m_out.line;
    assign m_data_dest       = m_out.dest;
    assign m_proc_data_ready = m_out.ready;
    assign m_assert_shared   = m_out.ashared;
    assign m_miss_flag       = m_out.miss;
    assign m_upgrade_flag    = m_out.upg;
    assign m_illegal_flag    = m_out.illegal;
    assign m_line_state_out  = m_out.nst;

endmodule

// ----- rtl/core/mlcc_front.sv -----
// Front end: decodes the request mode and queues classified beats for the back end.
module mlcc_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept_en,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_mode,
    input  logic [mlcc_pkg::LINE_W-1:0] s_line_index,
    input  logic [mlcc_pkg::NODE_W-1:0] s_source_node,
    input  logic                        s_shared_in,
    output logic                        q_valid,
    input  logic                        q_ready,
    output mlcc_pkg::item_t             q_item
);

    mlcc_pkg::item_t                 slot_reg [mlcc_pkg::QDEPTH];
    logic [mlcc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [mlcc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [mlcc_pkg::QCNT_W-1:0]     count_reg, count_next;
    mlcc_pkg::item_t                 item_in;
    logic                            push, pop;

    always_comb begin
        item_in.idx    = s_line_index;
        item_in.src    = s_source_node;
        item_in.shared = s_shared_in;
        unique case (s_mode)
            mlcc_pkg::MD_LOAD:  item_in.op = mlcc_pkg::OP_LOAD;
            mlcc_pkg::MD_STORE: item_in.op = mlcc_pkg::OP_STORE;
            mlcc_pkg::MD_GETS:  item_in.op = mlcc_pkg::OP_GETS;
            mlcc_pkg::MD_GETM:  item_in.op = mlcc_pkg::OP_GETM;
            mlcc_pkg::MD_DATA:  item_in.op = mlcc_pkg::OP_DATA;
            default:            item_in.op = mlcc_pkg::OP_BAD;
        endcase
    end

    assign s_ready = accept_en && (count_reg != mlcc_pkg::QCNT_W'(mlcc_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= item_in;
    end

endmodule

// ----- rtl/core/mlcc_back.sv -----
// Back end: line state memory, read-modify-write sequencer and result register.
module mlcc_back (
    input  logic            aclk,
    input  logic            aresetn,
    output logic            init_done,
    input  logic            q_valid,
    output logic            q_ready,
    input  mlcc_pkg::item_t q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output mlcc_pkg::out_t  m_out
);

    logic [2:0]                   mem [mlcc_pkg::NUM_LINES];
    logic [2:0]                   rd_data_reg;

    mlcc_pkg::bk_state_t          state_reg, state_next;
    logic [mlcc_pkg::LINE_W-1:0]  clr_cnt_reg, clr_cnt_next;
    mlcc_pkg::item_t              cur_reg, cur_next;
    mlcc_pkg::out_t               out_reg, out_next;
    logic                         m_valid_reg, m_valid_next;

    mlcc_pkg::coh_res_t           res;
    logic                         out_free;
    logic                         clr_last;
    logic                         mem_we;
    logic [mlcc_pkg::LINE_W-1:0]  mem_waddr, mem_raddr;
    logic [2:0]                   mem_wdata;
    logic                         load_out;

    assign res       = mlcc_pkg::coh_step(rd_data_reg, cur_reg.op, cur_reg.shared);
    assign out_free  = !m_valid_reg || m_ready;
    assign clr_last  = (clr_cnt_reg == mlcc_pkg::LINE_W'(mlcc_pkg::NUM_LINES - 1));
    assign init_done = (state_reg != mlcc_pkg::BK_CLEAR);
    assign m_valid   = m_valid_reg;
    assign m_out     = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mlcc_pkg::BK_CLEAR: if (clr_last) state_next = mlcc_pkg::BK_IDLE;
            mlcc_pkg::BK_IDLE:  if (q_valid) state_next = mlcc_pkg::BK_LOOK;
            mlcc_pkg::BK_LOOK:  if (out_free) state_next = mlcc_pkg::BK_IDLE;
            default:            state_next = mlcc_pkg::BK_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        q_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = mlcc_pkg::LS_I;
        mem_raddr = cur_reg.idx;
        load_out  = 1'b0;
        unique case (state_reg)
            mlcc_pkg::BK_CLEAR: mem_we = 1'b1;
            mlcc_pkg::BK_IDLE: begin
                q_ready   = 1'b1;
                mem_raddr = q_item.idx;
            end
            mlcc_pkg::BK_LOOK: begin
                // write back and hand over the result in one go; hold while the output is full
                if (out_free) begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg.idx;
                    mem_wdata = res.nst;
                    load_out  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        clr_cnt_next = (state_reg == mlcc_pkg::BK_CLEAR) ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        cur_next     = (q_valid && q_ready) ? q_item : cur_reg;
        m_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        out_next     = out_reg;
        if (load_out) begin
            out_next.bus     = res.bus;
            out_next.line    = (res.bus != mlcc_pkg::BUS_NONE) ? cur_reg.idx : '0;
            out_next.dest    = (res.bus == mlcc_pkg::BUS_DATA) ? cur_reg.src : '0;
            out_next.ready   = res.ready;
            out_next.ashared = res.ashared;
            out_next.miss    = res.miss;
            out_next.upg     = res.upg;
            out_next.illegal = res.illegal;
            out_next.nst     = res.nst;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mlcc_pkg::BK_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

// ----- rtl/core/mlcc_checker.sv -----
// Port-level checks of the MESI line controller, bound to the top level.
module mlcc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [1:0]                  m_bus_request,
    input logic [mlcc_pkg::LINE_W-1:0] m_bus_line,
    input logic [mlcc_pkg::NODE_W-1:0] m_data_dest,
    input logic                        m_proc_data_ready,
    input logic                        m_assert_shared,
    input logic                        m_miss_flag,
    input logic                        m_upgrade_flag,
    input logic                        m_illegal_flag,
    input logic [2:0]                  m_line_state_out
);

    // reset starts the clearing pass: nothing taken, nothing offered
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("beat moved straight after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bus_request) && $stable(m_bus_line)
            && $stable(m_data_dest) && $stable(m_line_state_out))
        else $error("stalled result beat changed");

    a_idle_bus: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bus_request == mlcc_pkg::BUS_NONE |-> m_bus_line == '0 && m_data_dest == '0)
        else $error("bus fields set without a bus request");

    a_illegal_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_illegal_flag |-> m_bus_request == mlcc_pkg::BUS_NONE
            && !m_proc_data_ready && !m_miss_flag && !m_upgrade_flag && !m_assert_shared)
        else $error("illegal beat carried an action");

    a_upgrade_m: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_upgrade_flag |-> m_line_state_out == mlcc_pkg::LS_M && m_proc_data_ready)
        else $error("silent upgrade did not end in M");

endmodule

bind mesi_line_coherence_controller mlcc_checker u_mlcc_checker (.*);
